[design/amhm_pkg.sv]
// amhm_pkg: shared constants and types for the address mode histogram monitor
// depends on nothing
package amhm_pkg;
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned AddrW = 24;
  localparam int unsigned CountW = 32;
  localparam int unsigned ThreshW = 16;
  localparam logic [31:0] HashMult = 32'd2654435761;
  localparam logic [ThreshW-1:0] ThreshReset = 16'd64;
  localparam logic [CountW-1:0] CountMax = '1;
  // one memory word holds the tag, the warned mark and all four counters
  localparam int unsigned EntryW = AddrW + 1 + 4 * CountW;

  typedef struct packed {
    logic [AddrW-1:0] tag;
    logic warned;
    logic [3:0][CountW-1:0] cnt;
  } entry_t;

  typedef enum logic {
    ReqRecord = 1'b0,
    ReqQuery = 1'b1
  } req_e;
endpackage

[design/amhm_ram.sv]
// amhm_ram: generic single-port synchronous ram, registered read
// depends on nothing
module amhm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[design/amhm_update.sv]
// amhm_update: combinational entry update for one item once the slot is known
// depends on amhm_pkg
module amhm_update (
  input  amhm_pkg::entry_t           entry_i,
  input  logic                       query_i,
  input  logic [1:0]                 combo_i,
  input  logic [amhm_pkg::AddrW-1:0] addr_i,
  input  logic [amhm_pkg::ThreshW-1:0] thresh_i,
  output amhm_pkg::entry_t           entry_o,
  output logic [amhm_pkg::CountW-1:0] count_o,
  output logic                       flag_o,
  output logic [1:0]                 prior_o
);
  logic [1:0] best01, best23;
  logic [amhm_pkg::CountW-1:0] cur, inc, bestc01, bestc23;

  always_comb begin
    // ties go to the lower index
    best01 = (entry_i.cnt[1] > entry_i.cnt[0]) ? 2'd1 : 2'd0;
    bestc01 = entry_i.cnt[best01];
    best23 = (entry_i.cnt[3] > entry_i.cnt[2]) ? 2'd3 : 2'd2;
    bestc23 = entry_i.cnt[best23];
    prior_o = (bestc23 > bestc01) ? best23 : best01;
    cur = entry_i.cnt[combo_i];
    inc = (cur == amhm_pkg::CountMax) ? cur : cur + 1'b1;
    flag_o = !query_i && !entry_i.warned && (cur == '0) &&
             ({16'd0, thresh_i} <= entry_i.cnt[prior_o]) && (prior_o != combo_i);
    entry_o = entry_i;
    if (!query_i) begin
      entry_o.tag = addr_i;
      entry_o.cnt[combo_i] = inc;
      if (flag_o) begin
        entry_o.warned = 1'b1;
      end
    end
    count_o = query_i ? cur : inc;
  end
endmodule

[design/address_mode_histogram_monitor_core.sv]
// address_mode_histogram_monitor_core: top level, probe sequencer around one entry memory
// depends on amhm_pkg, amhm_ram, amhm_update
// Each probe of an item on the single entry memory steps through an address
// state, a read state and a compare state (StRead, StWait, StCheck). The number
// of slots probed is 1 on an uncrowded table and up to the table size. The result
// is registered from the compare state of the last probe. A record that finds or
// claims its entry adds a write state, and the next item is accepted only once
// the previous one is finished. After reset a clearing pass writes all 4096
// entries to zero, and busy is high meanwhile. Results appear for one cycle with
// valid_o and cannot be held.
module address_mode_histogram_monitor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [23:0] code_address_i,
  input  logic        mem_wide_flag_i,
  input  logic        index_wide_flag_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        valid_o,
  output logic        found_o,
  output logic [31:0] occurrence_count_o,
  output logic        mode_change_o,
  output logic [1:0]  prior_mode_o
);
  localparam int unsigned SW = amhm_pkg::SlotW;

  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StWait, StCheck, StWrite
  } state_e;

  state_e state_q;
  logic [SW-1:0] slot_q, home;
  logic [SW:0] steps_q;
  logic query_q;
  logic [1:0] combo_q;
  logic [amhm_pkg::AddrW-1:0] addr_q;
  logic [amhm_pkg::ThreshW-1:0] thresh_q;
  logic [31:0] hash;
  logic we;
  logic [SW-1:0] raddr;
  amhm_pkg::entry_t wentry, rentry, upd;
  logic [amhm_pkg::EntryW-1:0] rdata;
  logic [31:0] cnt;
  logic flag;
  logic [1:0] prior;

  assign hash = {8'd0, code_address_i} * amhm_pkg::HashMult;
  assign home = hash[SW-1:0];
  assign rentry = amhm_pkg::entry_t'(rdata);

  amhm_update u_upd (
    .entry_i(rentry), .query_i(query_q), .combo_i(combo_q), .addr_i(addr_q),
    .thresh_i(thresh_q), .entry_o(upd), .count_o(cnt), .flag_o(flag),
    .prior_o(prior)
  );

  always_comb begin
    we = 1'b0;
    wentry = upd;
    if (state_q == StClear) begin
      we = 1'b1;
      wentry = '0;
    end else if (state_q == StWrite) begin
      we = 1'b1;
    end
  end
  assign raddr = slot_q;

  amhm_ram #(.Width(amhm_pkg::EntryW), .Depth(amhm_pkg::TableEntries)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(raddr), .wdata_i(wentry), .rdata_o(rdata)
  );

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      slot_q <= '0;
      steps_q <= '0;
      thresh_q <= amhm_pkg::ThreshReset;
      valid_o <= 1'b0;
      query_q <= 1'b0;
      combo_q <= '0;
      addr_q <= '0;
      found_o <= 1'b0;
      occurrence_count_o <= '0;
      mode_change_o <= 1'b0;
      prior_mode_o <= '0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      case (state_q)
        StClear: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == SW'(amhm_pkg::TableEntries - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (start) begin
            query_q <= req_type_i;
            addr_q <= code_address_i;
            combo_q <= {mem_wide_flag_i, index_wide_flag_i};
            slot_q <= home;
            steps_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StWait;
        StWait: state_q <= StCheck;
        StCheck: begin
          if (rentry.tag == addr_q || rentry.tag == '0) begin
            if (rentry.tag == '0 && query_q == amhm_pkg::ReqQuery && addr_q != '0) begin
              valid_o <= 1'b1;
              found_o <= 1'b0;
              occurrence_count_o <= '0;
              mode_change_o <= 1'b0;
              prior_mode_o <= '0;
              state_q <= StIdle;
            end else begin
              valid_o <= 1'b1;
              found_o <= 1'b1;
              occurrence_count_o <= cnt;
              mode_change_o <= flag;
              prior_mode_o <= prior;
              state_q <= (query_q == amhm_pkg::ReqQuery) ? StIdle : StWrite;
            end
          end else if (steps_q == (SW+1)'(amhm_pkg::TableEntries - 1)) begin
            // whole table probed
            valid_o <= 1'b1;
            found_o <= 1'b0;
            occurrence_count_o <= '0;
            mode_change_o <= 1'b0;
            prior_mode_o <= '0;
            state_q <= StIdle;
          end else begin
            slot_q <= slot_q + 1'b1;
            steps_q <= steps_q + 1'b1;
            state_q <= StRead;
          end
        end
        StWrite: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[design/amhm_checker.sv]
// amhm_checker: port-level assertions for the monitor, bound to the top level
// depends on address_mode_histogram_monitor_core
module amhm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        req_type_i,
  input logic        valid_o,
  input logic        found_o,
  input logic [31:0] occurrence_count_o,
  input logic        mode_change_o,
  input logic [1:0]  prior_mode_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without item in work");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (occurrence_count_o == '0 && !mode_change_o &&
    prior_mode_o == '0)) else $error("miss carries data");
  a_flag_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && mode_change_o) |-> (found_o && occurrence_count_o == 32'd1))
    else $error("mode change on bad result");
endmodule

bind address_mode_histogram_monitor_core amhm_checker u_chk (.*);

[sim/tb_top.sv]
// tb_top: self-checking bench for address_mode_histogram_monitor_core
// drives record and query items, predicts every result from its own copy of the
// hash table, depends on amhm_pkg and the core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [31:0] count;
    logic        change;
    logic [1:0]  prior;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = 1'b0;
  logic [23:0] code_address_i = '0;
  logic        mem_wide_flag_i = 1'b0;
  logic        index_wide_flag_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        valid_o;
  logic        found_o;
  logic [31:0] occurrence_count_o;
  logic        mode_change_o;
  logic [1:0]  prior_mode_o;

  // table copy kept by the bench
  logic [23:0] hist_tag [amhm_pkg::TableEntries];
  logic [31:0] hist_cnt [amhm_pkg::TableEntries][4];
  logic        hist_warned [amhm_pkg::TableEntries];
  logic [15:0] warmup_q = amhm_pkg::ThreshReset;

  outcome_t pending_q[$];
  int       errors = 0;
  int       idle_pct = 0;
  int       n_items = 0;
  int       n_flags = 0;
  int       n_missed = 0;
  logic [23:0] addr_pool [16];

  address_mode_histogram_monitor_core dut (.*);

  always #5ns clk_i = ~clk_i;

  function automatic outcome_t predict_outcome(logic query, logic [23:0] addr,
                                               logic [1:0] combo);
    logic [31:0] prod;
    logic [11:0] s;
    int          slot;
    logic [1:0]  lead;
    outcome_t    r;
    slot = -1;
    r = '0;
    prod = {8'b0, addr} * amhm_pkg::HashMult;
    for (int step = 0; step < amhm_pkg::TableEntries; step++) begin
      s = prod[11:0] + step[11:0];
      if (hist_tag[s] == addr) begin
        slot = s;
        break;
      end
      if (hist_tag[s] == '0) begin
        if (!query) begin
          hist_tag[s] = addr;
          slot = s;
        end
        break;
      end
    end
    if (slot < 0) return r;
    lead = 2'd0;
    for (int k = 1; k < 4; k++)
      if (hist_cnt[slot][k] > hist_cnt[slot][lead]) lead = k[1:0];
    if (!query) begin
      if (!hist_warned[slot] && hist_cnt[slot][combo] == 0 &&
          hist_cnt[slot][lead] >= {16'b0, warmup_q} && lead != combo) begin
        hist_warned[slot] = 1'b1;
        r.change = 1'b1;
      end
      if (hist_cnt[slot][combo] != amhm_pkg::CountMax) hist_cnt[slot][combo]++;
    end
    r.found = 1'b1;
    r.count = hist_cnt[slot][combo];
    r.prior = lead;
    return r;
  endfunction

  task automatic send_item(amhm_pkg::req_e req, logic [23:0] addr, logic [1:0] combo);
    outcome_t o;
    start <= 1'b1;
    req_type_i <= req;
    code_address_i <= addr;
    mem_wide_flag_i <= combo[1];
    index_wide_flag_i <= combo[0];
    do @(posedge clk_i); while (busy);
    o = predict_outcome(req == amhm_pkg::ReqQuery, addr, combo);
    pending_q.push_back(o);
    n_items++;
    if (o.change) n_flags++;
    if (!o.found) n_missed++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every outstanding result arrive
  task automatic go_quiet();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_warmup(logic [15:0] value);
    go_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    warmup_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, found %0d count %0d", $time,
                 found_o, occurrence_count_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (found_o !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $time, e.found, found_o);
          errors++;
        end
        if (occurrence_count_o !== e.count) begin
          $display("%0t: occurrence_count expected %0d actual %0d", $time, e.count,
                   occurrence_count_o);
          errors++;
        end
        if (mode_change_o !== e.change) begin
          $display("%0t: mode_change expected %0d actual %0d", $time, e.change,
                   mode_change_o);
          errors++;
        end
        if (prior_mode_o !== e.prior) begin
          $display("%0t: prior_mode expected %0d actual %0d", $time, e.prior,
                   prior_mode_o);
          errors++;
        end
      end
    end
  end

  // address zero shares an empty slot until a real address claims it
  task automatic test_address_zero();
    send_item(amhm_pkg::ReqRecord, 24'h0, 2'd0);
    send_item(amhm_pkg::ReqQuery, 24'h0, 2'd0);
    send_item(amhm_pkg::ReqRecord, 24'h000000, 2'd0);
    send_item(amhm_pkg::ReqRecord, 24'h001000, 2'd1);
    send_item(amhm_pkg::ReqQuery, 24'h001000, 2'd0);
    send_item(amhm_pkg::ReqQuery, 24'h0, 2'd2);
    send_item(amhm_pkg::ReqRecord, 24'h0, 2'd3);
  endtask

  task automatic test_field_extremes();
    send_item(amhm_pkg::ReqQuery, 24'hffffff, 2'd3);
    send_item(amhm_pkg::ReqRecord, 24'hffffff, 2'd3);
    send_item(amhm_pkg::ReqQuery, 24'hffffff, 2'd3);
    send_item(amhm_pkg::ReqRecord, 24'h800000, 2'd2);
    send_item(amhm_pkg::ReqRecord, 24'h000001, 2'd1);
    send_item(amhm_pkg::ReqQuery, 24'h000001, 2'd0);
  endtask

  task automatic test_mode_change();
    write_warmup(16'd2);
    send_item(amhm_pkg::ReqRecord, 24'h123456, 2'd0);
    send_item(amhm_pkg::ReqRecord, 24'h123456, 2'd0);
    send_item(amhm_pkg::ReqRecord, 24'h123456, 2'd2);
    send_item(amhm_pkg::ReqRecord, 24'h123456, 2'd1);
    send_item(amhm_pkg::ReqQuery, 24'h123456, 2'd2);
    write_warmup(16'd0);
    send_item(amhm_pkg::ReqRecord, 24'h654321, 2'd3);
    send_item(amhm_pkg::ReqRecord, 24'h654321, 2'd0);
    write_warmup(16'hffff);
    send_item(amhm_pkg::ReqRecord, 24'h0abcde, 2'd1);
    send_item(amhm_pkg::ReqRecord, 24'h0abcde, 2'd2);
  endtask

  task automatic test_random_traffic();
    int          pcts [3] = '{0, 68, 10};
    logic [15:0] thr [4] = '{16'd3, 16'd0, 16'hffff, 16'd64};
    logic [23:0] addr;
    logic [1:0]  combo;
    for (int i = 0; i < 16; i++)
      addr_pool[i] = (i < 4) ? {12'($urandom), 12'h000} : 24'($urandom);
    addr_pool[15] = 24'h0;
    for (int ph = 0; ph < 4; ph++) begin
      write_warmup(ph == 3 ? 16'($urandom_range(1, 40)) : thr[ph]);
      idle_pct = pcts[ph % 3];
      for (int n = 0; n < 260; n++) begin
        addr = ($urandom_range(99) < 65) ? addr_pool[$urandom_range(15)] : 24'($urandom);
        // a leading combination per address makes departures likely
        combo = ($urandom_range(99) < 75) ? addr[1:0] : 2'($urandom);
        send_item(($urandom_range(99) < 30) ? amhm_pkg::ReqQuery : amhm_pkg::ReqRecord,
                  addr, combo);
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    for (int s = 0; s < amhm_pkg::TableEntries; s++) begin
      hist_tag[s] = '0;
      hist_warned[s] = 1'b0;
      for (int k = 0; k < 4; k++) hist_cnt[s][k] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_address_zero();
    test_field_extremes();
    test_mode_change();
    test_random_traffic();
    go_quiet();
    repeat (40) @(posedge clk_i);
    $display("covered %0d items: %0d mode changes, %0d query misses", n_items, n_flags,
             n_missed);
    $display("address zero sharing, extreme addresses and several warm-up levels");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
